// ===== design/hsm_pkg.sv =====
// Shared constants, codes and constant functions for the Hessian sheet measure block.
package hsm_pkg;

    // Default eigenvalue width (signed Q16.16)
    localparam int EIGEN_BITS_DEF = 32;

    // Internal fixed-point formats
    localparam int Q_BITS      = 30;  // ratio and weight fraction bits (Q1.30)
    localparam int LOG_BITS    = 20;  // log2 fraction bits (Q5.20)
    localparam int ALPHA_SHIFT = 12;  // alpha is Q4.12
    localparam int GAMMA_SHIFT = 12;  // gamma is Q4.12
    localparam int NORM_STEPS  = 5;   // 16/8/4/2/1 normalize steps
    localparam int CFG_BITS    = 16;  // widest register

    // Weight lane latency: operand reg, divider, base, normalize, log, gamma, exp, final
    localparam int LANE_LAT = 1 + Q_BITS + 1 + NORM_STEPS + LOG_BITS + 1 + LOG_BITS + 1;

    // Register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_ALPHA = 2'd1;
    localparam logic [1:0] CFG_GAMMA = 2'd2;

    // Measure modes
    localparam logic [1:0] MODE_BRIGHT = 2'd0;
    localparam logic [1:0] MODE_DARK   = 2'd1;
    localparam logic [1:0] MODE_FOLD   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;  // unused, response 0

    // Register reset values
    localparam logic [1:0]          MODE_RST  = MODE_DARK;
    localparam logic [CFG_BITS-1:0] ALPHA_RST = 16'd1024;
    localparam logic [CFG_BITS-1:0] GAMMA_RST = 16'd2048;

    // c_k = 2^(-2^-k) in Q1.30, c_0 = 0.5, c_k = isqrt(c_(k-1) << 30)
    function automatic logic [30:0] exp_const(input int k);
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd1 << 29;
        for (int j = 1; j <= LOG_BITS; j++) begin
            if (j <= k) begin
                v = c << Q_BITS;
                r = 64'd0;
                b = 64'd1 << 62;
                for (int i = 0; i < 32; i++) begin
                    if (v >= r + b) begin
                        v = v - r - b;
                        r = (r >> 1) + b;
                    end else begin
                        r = r >> 1;
                    end
                    b = b >> 2;
                end
                c = r;
            end
        end
        return c[30:0];
    endfunction

endpackage

// ===== design/hsm_weight.sv =====
// One weight lane: ratio divider, log2, gamma scaling and exp2, fully pipelined.
module hsm_weight #(
    parameter int DEN_BITS = hsm_pkg::EIGEN_BITS_DEF + hsm_pkg::ALPHA_SHIFT
) (
    input  logic                i_clk,
    input  logic [DEN_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    input  logic                i_zero,
    input  logic [15:0]         i_gamma,
    output logic [30:0]         o_weight
);

    localparam int QB = hsm_pkg::Q_BITS;
    localparam int LB = hsm_pkg::LOG_BITS;
    localparam int NS = hsm_pkg::NORM_STEPS;
    localparam logic [30:0] ONE = 31'd1 << QB;

    // Divider stages
    logic [DEN_BITS-1:0] r_d_rem  [0:QB];
    logic [DEN_BITS-1:0] r_d_den  [0:QB];
    logic [QB-1:0]       r_d_q    [0:QB];
    logic                r_d_full [0:QB];
    logic                r_d_zero [0:QB];

    // Normalize stages
    logic [30:0] r_n_x  [0:NS];
    logic [4:0]  r_n_sh [0:NS];
    logic        r_n_sp [0:NS];
    logic        r_n_sv [0:NS];

    // Log stages
    logic [30:0]   r_l_m  [1:LB];
    logic [LB-1:0] r_l_f  [1:LB];
    logic [4:0]    r_l_sh [1:LB];
    logic          r_l_sp [1:LB];
    logic          r_l_sv [1:LB];

    // Gamma stage
    logic [8:0]    r_g_n;
    logic [LB-1:0] r_g_f;
    logic          r_g_sp;
    logic          r_g_sv;
    logic [24:0]   g_negl;
    logic [40:0]   g_prod;

    // Exp stages
    logic [30:0]   r_e_acc [1:LB];
    logic [LB-1:0] r_e_f   [1:LB];
    logic [8:0]    r_e_n   [1:LB];
    logic          r_e_sp  [1:LB];
    logic          r_e_sv  [1:LB];

    logic [30:0] r_weight;

    // Operand capture
    always_ff @(posedge i_clk) begin
        r_d_rem[0]  <= i_num;
        r_d_den[0]  <= i_den;
        r_d_q[0]    <= '0;
        r_d_full[0] <= (i_num >= i_den);
        r_d_zero[0] <= i_zero;
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [DEN_BITS:0] two;
        logic [DEN_BITS:0] sub;
        logic              take;
        assign two  = {r_d_rem[k], 1'b0};
        assign sub  = two - {1'b0, r_d_den[k]};
        assign take = (two >= {1'b0, r_d_den[k]});
        always_ff @(posedge i_clk) begin
            r_d_rem[k+1]  <= take ? sub[DEN_BITS-1:0] : two[DEN_BITS-1:0];
            r_d_den[k+1]  <= r_d_den[k];
            r_d_q[k+1]    <= {r_d_q[k][QB-2:0], take};
            r_d_full[k+1] <= r_d_full[k];
            r_d_zero[k+1] <= r_d_zero[k];
        end
    end

    // Base and special weights: sp marks a fixed result, sv picks one or zero
    always_ff @(posedge i_clk) begin
        r_n_x[0]  <= r_d_full[QB] ? ONE : {1'b0, r_d_q[QB]};
        r_n_sh[0] <= '0;
        if (r_d_zero[QB]) begin
            r_n_sp[0] <= 1'b1;
            r_n_sv[0] <= 1'b0;
        end else if (i_gamma == '0 || r_d_full[QB]) begin
            r_n_sp[0] <= 1'b1;
            r_n_sv[0] <= 1'b1;
        end else if (r_d_q[QB] == '0) begin
            r_n_sp[0] <= 1'b1;
            r_n_sv[0] <= 1'b0;
        end else begin
            r_n_sp[0] <= 1'b0;
            r_n_sv[0] <= 1'b0;
        end
    end

    // Bring the leading one to bit 30, counting the shift
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int S = 16 >> j;
        always_ff @(posedge i_clk) begin
            if (r_n_x[j][30 -: S] == '0) begin
                r_n_x[j+1]  <= r_n_x[j] << S;
                r_n_sh[j+1] <= r_n_sh[j] + 5'(S);
            end else begin
                r_n_x[j+1]  <= r_n_x[j];
                r_n_sh[j+1] <= r_n_sh[j];
            end
            r_n_sp[j+1] <= r_n_sp[j];
            r_n_sv[j+1] <= r_n_sv[j];
        end
    end

    // Log2 fraction by repeated squaring, one bit per stage
    for (genvar k = 1; k <= LB; k++) begin : g_log
        logic [30:0]   m_in;
        logic [LB-1:0] f_in;
        logic [4:0]    sh_in;
        logic          sp_in;
        logic          sv_in;
        logic [61:0]   sq;
        if (k == 1) begin : g_first
            assign m_in  = r_n_x[NS];
            assign f_in  = '0;
            assign sh_in = r_n_sh[NS];
            assign sp_in = r_n_sp[NS];
            assign sv_in = r_n_sv[NS];
        end else begin : g_next
            assign m_in  = r_l_m[k-1];
            assign f_in  = r_l_f[k-1];
            assign sh_in = r_l_sh[k-1];
            assign sp_in = r_l_sp[k-1];
            assign sv_in = r_l_sv[k-1];
        end
        assign sq = 62'(m_in) * 62'(m_in);
        always_ff @(posedge i_clk) begin
            if (sq[61]) begin
                r_l_m[k] <= sq[61:31];
                r_l_f[k] <= {f_in[LB-2:0], 1'b1};
            end else begin
                r_l_m[k] <= sq[60:30];
                r_l_f[k] <= {f_in[LB-2:0], 1'b0};
            end
            r_l_sh[k] <= sh_in;
            r_l_sp[k] <= sp_in;
            r_l_sv[k] <= sv_in;
        end
    end

    // -log2(base) times gamma
    assign g_negl = {r_l_sh[LB], {LB{1'b0}}} - {5'd0, r_l_f[LB]};
    assign g_prod = 41'(i_gamma) * 41'(g_negl);

    always_ff @(posedge i_clk) begin
        r_g_n  <= g_prod[40:32];
        r_g_f  <= g_prod[31:hsm_pkg::GAMMA_SHIFT];
        r_g_sp <= r_l_sp[LB];
        r_g_sv <= r_l_sv[LB];
    end

    // 2^-frac as a product of constants, one constant per stage
    for (genvar k = 1; k <= LB; k++) begin : g_exp
        localparam logic [30:0] C = hsm_pkg::exp_const(k);
        logic [30:0]   acc_in;
        logic [LB-1:0] f_in;
        logic [8:0]    n_in;
        logic          sp_in;
        logic          sv_in;
        logic [60:0]   prod;
        if (k == 1) begin : g_first
            assign acc_in = ONE;
            assign f_in   = r_g_f;
            assign n_in   = r_g_n;
            assign sp_in  = r_g_sp;
            assign sv_in  = r_g_sv;
        end else begin : g_next
            assign acc_in = r_e_acc[k-1];
            assign f_in   = r_e_f[k-1];
            assign n_in   = r_e_n[k-1];
            assign sp_in  = r_e_sp[k-1];
            assign sv_in  = r_e_sv[k-1];
        end
        assign prod = 61'(acc_in) * 61'(C);
        always_ff @(posedge i_clk) begin
            r_e_acc[k] <= f_in[LB-k] ? prod[60:30] : acc_in;
            r_e_f[k]   <= f_in;
            r_e_n[k]   <= n_in;
            r_e_sp[k]  <= sp_in;
            r_e_sv[k]  <= sv_in;
        end
    end

    // Integer part of the exponent as a right shift
    always_ff @(posedge i_clk) begin
        if (r_e_sp[LB]) begin
            r_weight <= r_e_sv[LB] ? ONE : '0;
        end else if (r_e_n[LB] >= 9'd31) begin
            r_weight <= '0;
        end else begin
            r_weight <= r_e_acc[LB] >> r_e_n[LB][4:0];
        end
    end

    assign o_weight = r_weight;

endmodule

// ===== design/hessian_sheet_measure.sv =====
// Top level of the Hessian sheet/fold structure response for one voxel per request.
// Throughput: one request per cycle; the receiver cannot stall, and the divider,
// log and exp chains of both weight lanes advance one step per stage.
// Reset (synchronous, active low) drops all requests in flight and restores
// mode, alpha and gamma to their defaults; busy is high only while reset is held.
module hessian_sheet_measure #(
    parameter int EIGEN_BITS = hsm_pkg::EIGEN_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [EIGEN_BITS-1:0] i_lambda_largest,
    input  logic signed [EIGEN_BITS-1:0] i_lambda_middle,
    input  logic signed [EIGEN_BITS-1:0] i_lambda_smallest,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [hsm_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic                         o_done,
    output logic [EIGEN_BITS-1:0]        o_response,
    output logic                         o_degenerate
);

    localparam int EB     = EIGEN_BITS;
    localparam int DW     = EB + hsm_pkg::ALPHA_SHIFT;
    localparam int PW     = EB + 16;
    localparam int HB     = EB / 2;
    localparam int LOW_W  = HB + 31;
    localparam int HIGH_W = EB - HB + 31;
    localparam int SUM_W  = EB + 31;
    localparam int LAT    = hsm_pkg::LANE_LAT;
    localparam int TOTAL  = LAT + 5;

    typedef struct packed {
        logic          active;
        logic          degen;
        logic [EB-1:0] mag;
    } t_side;

    function automatic logic [EB-1:0] mag(input logic [EB-1:0] x);
        return x[EB-1] ? (~x + 1'b1) : x;
    endfunction

    // Configuration
    logic [1:0]  r_mode;
    logic [15:0] r_alpha;
    logic [15:0] r_gamma;

    // Stage A
    logic                 a_take;
    logic signed [EB-1:0] a_s [0:1];
    logic signed [EB-1:0] a_t [0:1];
    logic [EB-1:0]        a_op [0:1];
    logic                 a_dark;
    logic                 a_active;
    logic [EB-1:0]        a_m;

    logic                 r_a_valid;
    logic                 r_a_active;
    logic                 r_a_dark;
    logic [EB-1:0]        r_a_m;
    logic signed [EB-1:0] r_a_s [0:1];
    logic signed [EB-1:0] r_a_t [0:1];
    logic [PW-1:0]        r_a_prod [0:1];

    // Stage B
    logic [DW-1:0] b_num [0:1];
    logic [DW-1:0] b_den [0:1];
    logic          b_zero [0:1];
    logic          b_deg [0:1];

    logic          r_b_valid;
    t_side         r_b_side;
    logic [DW-1:0] r_b_num [0:1];
    logic [DW-1:0] r_b_den [0:1];
    logic          r_b_zero [0:1];

    // Lanes and side delay line
    logic [30:0]    w_lane [0:1];
    logic [LAT-1:0] r_sdv;
    t_side          r_sd [0:LAT-1];

    // Back end
    logic [61:0]       w_prod;
    logic              r_w_valid;
    t_side             r_w_side;
    logic [30:0]       r_w_weight;
    logic              r_p_valid;
    t_side             r_p_side;
    logic [LOW_W-1:0]  r_p_lo;
    logic [HIGH_W-1:0] r_p_hi;
    logic [SUM_W-1:0]  w_sum;
    logic [EB:0]       w_q;
    logic              r_done;
    logic [EB-1:0]     r_response;
    logic              r_degenerate;

    assign busy   = ~i_rst_n;
    assign a_take = start && !busy;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hsm_pkg::MODE_RST;
            r_alpha <= hsm_pkg::ALPHA_RST;
            r_gamma <= hsm_pkg::GAMMA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hsm_pkg::CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                hsm_pkg::CFG_ALPHA: r_alpha <= i_cfg_data;
                hsm_pkg::CFG_GAMMA: r_gamma <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lane operand selection by mode
    always_comb begin
        a_s[0]   = i_lambda_middle;
        a_t[0]   = i_lambda_smallest;
        a_s[1]   = i_lambda_largest;
        a_t[1]   = i_lambda_smallest;
        a_dark   = 1'b0;
        a_active = 1'b0;
        a_m      = mag(i_lambda_smallest);
        case (r_mode)
            hsm_pkg::MODE_BRIGHT: begin
                a_active = (i_lambda_smallest < 0);
            end
            hsm_pkg::MODE_DARK: begin
                a_s[0]   = i_lambda_largest;
                a_t[0]   = i_lambda_middle;
                a_dark   = 1'b1;
                a_active = (i_lambda_largest > 0);
                a_m      = mag(i_lambda_largest);
            end
            hsm_pkg::MODE_FOLD: begin
                a_t[1]   = i_lambda_middle;
                a_active = (i_lambda_smallest < 0);
            end
            default: ;
        endcase
        for (int j = 0; j < 2; j++) begin
            a_op[j] = a_dark ? mag(a_t[j]) : a_s[j];
        end
    end

    // Stage A: alpha products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= a_take;
        end
        r_a_active <= a_active;
        r_a_dark   <= a_dark;
        r_a_m      <= a_m;
        for (int j = 0; j < 2; j++) begin
            r_a_s[j]    <= a_s[j];
            r_a_t[j]    <= a_t[j];
            r_a_prod[j] <= PW'(r_alpha) * PW'(a_op[j]);
        end
    end

    // Stage B: branch choice, ratio numerator and divisor
    always_comb begin
        logic signed [EB-1:0] s;
        logic signed [EB-1:0] t;
        logic [EB-1:0]        diff;
        logic [EB-1:0]        d1;
        logic [DW-1:0]        d2;
        logic                 b1;
        logic                 b2;
        for (int j = 0; j < 2; j++) begin
            s    = r_a_s[j];
            t    = r_a_t[j];
            diff = s - t;
            if (r_a_dark) begin
                b1 = (s >= t) && (t >= 0);
                b2 = (t < 0);
                d1 = mag(s);
            end else begin
                b1 = (t <= s) && (s <= 0);
                b2 = (s > 0);
                d1 = mag(t);
            end
            d2 = {d1, {hsm_pkg::ALPHA_SHIFT{1'b0}}};
            b_deg[j] = b1 && (d1 == '0);
            if (b1) begin
                b_num[j]  = DW'(diff);
                b_den[j]  = DW'(d1);
                b_zero[j] = (d1 == '0);
            end else if (b2 && ({4'd0, d2} > r_a_prod[j])) begin
                b_num[j]  = d2 - r_a_prod[j][DW-1:0];
                b_den[j]  = d2;
                b_zero[j] = 1'b0;
            end else begin
                b_num[j]  = '0;
                b_den[j]  = '1;
                b_zero[j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_side.active <= r_a_active;
        r_b_side.degen  <= r_a_active && (b_deg[0] || b_deg[1]);
        r_b_side.mag    <= r_a_m;
        for (int j = 0; j < 2; j++) begin
            r_b_num[j]  <= b_num[j];
            r_b_den[j]  <= b_den[j];
            r_b_zero[j] <= b_zero[j];
        end
    end

    // Weight lanes
    for (genvar j = 0; j < 2; j++) begin : g_lane
        hsm_weight #(.DEN_BITS(DW)) u_weight (
            .i_clk    (i_clk),
            .i_num    (r_b_num[j]),
            .i_den    (r_b_den[j]),
            .i_zero   (r_b_zero[j]),
            .i_gamma  (r_gamma),
            .o_weight (w_lane[j])
        );
    end

    // Side data follows the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdv <= '0;
        end else begin
            r_sdv <= {r_sdv[LAT-2:0], r_b_valid};
        end
        r_sd[0] <= r_b_side;
        for (int i = 1; i < LAT; i++) begin
            r_sd[i] <= r_sd[i-1];
        end
    end

    // Combined weight
    assign w_prod = 62'(w_lane[0]) * 62'(w_lane[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else begin
            r_w_valid <= r_sdv[LAT-1];
        end
        r_w_side   <= r_sd[LAT-1];
        r_w_weight <= w_prod[60:30];
    end

    // Magnitude times weight as two partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= r_w_valid;
        end
        r_p_side <= r_w_side;
        r_p_lo   <= LOW_W'(r_w_side.mag[HB-1:0]) * LOW_W'(r_w_weight);
        r_p_hi   <= HIGH_W'(r_w_side.mag[EB-1:HB]) * HIGH_W'(r_w_weight);
    end

    // Sum, scale, saturate and gate
    assign w_sum = (SUM_W'(r_p_hi) << HB) + SUM_W'(r_p_lo);
    assign w_q   = w_sum[SUM_W-1:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_p_valid;
        end
        r_degenerate <= r_p_side.degen;
        if (!r_p_side.active || r_p_side.degen) begin
            r_response <= '0;
        end else if (w_q[EB]) begin
            r_response <= '1;
        end else begin
            r_response <= w_q[EB-1:0];
        end
    end

    assign o_done       = r_done;
    assign o_response   = r_response;
    assign o_degenerate = r_degenerate;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |-> (o_response == '0))
        else $error("degenerate result with nonzero response");

    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, TOTAL))
        else $error("result strobe without a matching request");
`endif

endmodule
